### hw/rtl/awa_pkg.sv
`default_nettype none

package awa_pkg;

    localparam int RAW_W     = 12;
    localparam int LUX_W     = 17;
    localparam int THR_W     = 17;
    localparam int LVL_W     = 2;
    localparam int OIDX_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam int LUX_MUL   = 9375;
    localparam int LUX_MUL_W = 14;
    localparam int LUX_SHIFT = 9;

    typedef logic [LVL_W-1:0] t_level;

    localparam t_level LVL_LOW  = 2'd0;
    localparam t_level LVL_MED  = 2'd1;
    localparam t_level LVL_HIGH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 1'd1;

    localparam logic [THR_W-1:0] LOW_THR_RST  = 17'd8000;
    localparam logic [THR_W-1:0] HIGH_THR_RST = 17'd24000;

endpackage

`default_nettype wire

### hw/rtl/adaptive_window_aggregator_core.sv
`default_nettype none
// An item that arrives while the window is still filling is only converted and stored. Once it is
// full, the first result is offered after the sum pass, the clamped difference and a square root of
// 17+clog2(WINDOW) compare-subtract steps, followed by the deviation scale and the level select.
// Each further result is prepared once the previous one is taken, so output stalls hold the item;
// an item gives 1, 3 or 12 results by default, and one item is in work at a time.
// Synchronous active-low reset clears the sequencer, fill count and write pointer and sets the
// thresholds to 8000 and 24000; the window memory is not cleared.
module adaptive_window_aggregator_core #(
    parameter int GROUP_SIZE  = 4,
    parameter int GROUP_COUNT = 3
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [awa_pkg::RAW_W-1:0]      i_sample_count,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [awa_pkg::LVL_W-1:0]           o_activity_level,
    output logic [awa_pkg::LUX_W-1:0]           o_aggregate_value,
    output logic [awa_pkg::LUX_W-1:0]           o_deviation,
    output logic [awa_pkg::OIDX_W-1:0]          o_item_index,
    output logic                                o_last_item,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [awa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [awa_pkg::THR_W-1:0]      i_cfg_data
);
    import awa_pkg::*;

    localparam int WINDOW  = GROUP_SIZE * GROUP_COUNT;
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int S1_W    = LUX_W + IDX_W;
    localparam int S2_W    = 2 * LUX_W + IDX_W;
    localparam int DIFF_W  = 2 * S1_W;
    localparam int HALF_W  = S1_W;
    localparam int CNT_MAX = (DIFF_W > WINDOW) ? DIFF_W : WINDOW;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int GI_W    = $clog2(GROUP_COUNT);
    localparam int GJ_W    = $clog2(GROUP_SIZE);

    localparam int     RCP_SH  = S1_W + IDX_W;
    localparam int     RCP_W   = RCP_SH;
    localparam longint RCP_WIN = ((longint'(1) << RCP_SH) + longint'(WINDOW) - 1)
                                 / longint'(WINDOW);
    localparam longint RCP_GRP = ((longint'(1) << RCP_SH) + longint'(GROUP_SIZE) - 1)
                                 / longint'(GROUP_SIZE);
    localparam logic [RCP_W-1:0] M_WIN = RCP_W'(RCP_WIN);
    localparam logic [RCP_W-1:0] M_GRP = RCP_W'(RCP_GRP);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LUX  = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_PREP = 4'd3;
    localparam logic [3:0] S_DIFF = 4'd4;
    localparam logic [3:0] S_DSCL = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_SEL  = 4'd7;
    localparam logic [3:0] S_ITEM = 4'd8;
    localparam logic [3:0] S_MSCL = 4'd9;
    localparam logic [3:0] S_MRD  = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    logic [3:0]              r_state, n_state;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [IDX_W-1:0]        r_wptr, n_wptr;
    logic [THR_W-1:0]        r_low, n_low;
    logic [THR_W-1:0]        r_high, n_high;

    logic [RAW_W-1:0]        r_raw, n_raw;
    logic [IDX_W-1:0]        r_newest, n_newest;
    logic [IDX_W-1:0]        r_rptr, n_rptr;
    logic [LUX_W-1:0]        r_rdata;
    logic [LUX_W-1:0]        r_d2, n_d2;
    logic [2*LUX_W-1:0]      r_sq, n_sq;
    logic                    r_p1, n_p1;
    logic                    r_p2, n_p2;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [S1_W-1:0]         r_s1, n_s1;
    logic [S2_W-1:0]         r_s2, n_s2;
    logic [S1_W-1:0]         r_gsum [GROUP_COUNT];
    logic [S1_W-1:0]         n_gsum [GROUP_COUNT];
    logic [GI_W-1:0]         r_gi, n_gi;
    logic [GJ_W-1:0]         r_gj, n_gj;
    logic [DIFF_W-1:0]       r_a, n_a;
    logic [DIFF_W-1:0]       r_b, n_b;
    logic [DIFF_W-1:0]       r_rem, n_rem;
    logic [DIFF_W-1:0]       r_root, n_root;
    logic [DIFF_W-1:0]       r_bit, n_bit;
    t_level                  r_level, n_level;
    logic [IDX_W-1:0]        r_ocnt, n_ocnt;
    logic [IDX_W-1:0]        r_lastidx, n_lastidx;
    logic [LUX_W-1:0]        r_value, n_value;
    logic [LUX_W-1:0]        r_dev, n_dev;
    logic [OIDX_W-1:0]       r_idx, n_idx;
    logic                    r_last, n_last;

    logic [LUX_W-1:0]        mem [WINDOW];

    logic [RAW_W+LUX_MUL_W-1:0] w_prod;
    logic [LUX_W-1:0]        w_lux;
    logic [FILL_W-1:0]       w_fill_next;
    logic [DIFF_W-1:0]       w_ua, w_ub, w_sub;
    logic                    w_ge;
    logic [S1_W-1:0]         w_mx;
    logic [RCP_W-1:0]        w_mm;
    logic [S1_W+RCP_W-1:0]   w_mprod;
    logic [LUX_W-1:0]        w_mq;

    assign w_prod = r_raw * LUX_MUL_W'(LUX_MUL);
    assign w_lux  = w_prod[LUX_SHIFT +: LUX_W];
    assign w_fill_next = (r_fill == FILL_W'(WINDOW)) ? r_fill : r_fill + FILL_W'(1);

    // One compare-subtract unit serves the clamp and the square root.
    always_comb begin
        unique case (r_state)
            S_DIFF: begin
                w_ua = r_a;
                w_ub = r_b;
            end
            default: begin
                w_ua = r_rem;
                w_ub = r_root + r_bit;
            end
        endcase
        w_ge  = (w_ua >= w_ub);
        w_sub = w_ua - w_ub;
    end

    // The deviation and the means divide by a constant through one reciprocal multiplier.
    always_comb begin
        priority if (r_state == S_DSCL) begin
            w_mx = r_root[HALF_W-1:0];
            w_mm = M_WIN;
        end else if (r_level == LVL_MED) begin
            w_mx = r_gsum[GI_W'(r_ocnt)];
            w_mm = M_GRP;
        end else begin
            w_mx = r_s1;
            w_mm = M_WIN;
        end
        w_mprod = w_mx * w_mm;
        w_mq    = w_mprod[RCP_SH +: LUX_W];
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_wptr    = r_wptr;
        n_low     = r_low;
        n_high    = r_high;
        n_raw     = r_raw;
        n_newest  = r_newest;
        n_rptr    = r_rptr;
        n_d2      = r_d2;
        n_sq      = r_sq;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_cnt     = r_cnt;
        n_s1      = r_s1;
        n_s2      = r_s2;
        n_gsum    = r_gsum;
        n_gi      = r_gi;
        n_gj      = r_gj;
        n_a       = r_a;
        n_b       = r_b;
        n_rem     = r_rem;
        n_root    = r_root;
        n_bit     = r_bit;
        n_level   = r_level;
        n_ocnt    = r_ocnt;
        n_lastidx = r_lastidx;
        n_value   = r_value;
        n_dev     = r_dev;
        n_idx     = r_idx;
        n_last    = r_last;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOW:  n_low  = i_cfg_data;
                CFG_HIGH: n_high = i_cfg_data;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_raw   = i_sample_count;
                    n_state = S_LUX;
                end
            end
            S_LUX: begin
                n_newest = r_wptr;
                n_rptr   = r_wptr;
                n_wptr   = (r_wptr == IDX_W'(WINDOW - 1)) ? '0 : r_wptr + IDX_W'(1);
                n_fill   = w_fill_next;
                n_cnt    = '0;
                n_p1     = 1'b0;
                n_p2     = 1'b0;
                n_s1     = '0;
                n_s2     = '0;
                n_gi     = '0;
                n_gj     = '0;
                n_state  = (w_fill_next == FILL_W'(WINDOW)) ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                if (r_cnt < CNT_W'(WINDOW)) begin
                    n_p1   = 1'b1;
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_rptr = (r_rptr == '0) ? IDX_W'(WINDOW - 1) : r_rptr - IDX_W'(1);
                end else begin
                    n_p1 = 1'b0;
                end
                n_p2 = r_p1;
                n_d2 = r_rdata;
                n_sq = r_rdata * r_rdata;
                if (r_p2) begin
                    n_s1 = r_s1 + S1_W'(r_d2);
                    n_s2 = r_s2 + S2_W'(r_sq);
                    if (r_gj == '0) begin
                        n_gsum[r_gi] = S1_W'(r_d2);
                    end else begin
                        n_gsum[r_gi] = r_gsum[r_gi] + S1_W'(r_d2);
                    end
                    if (r_gj == GJ_W'(GROUP_SIZE - 1)) begin
                        n_gj = '0;
                        n_gi = (r_gi == GI_W'(GROUP_COUNT - 1)) ? '0 : r_gi + GI_W'(1);
                    end else begin
                        n_gj = r_gj + GJ_W'(1);
                    end
                end
                if (r_cnt == CNT_W'(WINDOW) && !r_p1 && !r_p2) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_a     = DIFF_W'(r_s2) * DIFF_W'(WINDOW);
                n_b     = r_s1 * r_s1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_rem   = w_ge ? w_sub : '0;
                n_root  = '0;
                n_bit   = DIFF_W'(1) << (DIFF_W - 2);
                n_cnt   = CNT_W'(DIFF_W / 2);
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (w_ge) begin
                    n_rem  = w_sub;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DSCL;
                end
            end
            S_DSCL: begin
                n_dev   = w_mq;
                n_state = S_SEL;
            end
            S_SEL: begin
                priority if (r_dev <= r_low) begin
                    n_level   = LVL_LOW;
                    n_lastidx = '0;
                end else if (r_dev > r_high) begin
                    n_level   = LVL_HIGH;
                    n_lastidx = IDX_W'(WINDOW - 1);
                end else begin
                    n_level   = LVL_MED;
                    n_lastidx = IDX_W'(GROUP_COUNT - 1);
                end
                n_ocnt  = '0;
                n_rptr  = r_newest;
                n_state = S_ITEM;
            end
            S_ITEM: begin
                n_idx  = OIDX_W'(r_ocnt);
                n_last = (r_ocnt == r_lastidx);
                unique case (r_level)
                    LVL_HIGH: begin
                        n_state = S_MRD;
                    end
                    default: begin
                        n_state = S_MSCL;
                    end
                endcase
            end
            S_MSCL: begin
                n_value = w_mq;
                n_state = S_EMIT;
            end
            S_MRD: begin
                n_value = r_rdata;
                n_rptr  = (r_rptr == '0) ? IDX_W'(WINDOW - 1) : r_rptr - IDX_W'(1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ocnt  = r_ocnt + IDX_W'(1);
                        n_state = S_ITEM;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_wptr  <= '0;
            r_low   <= LOW_THR_RST;
            r_high  <= HIGH_THR_RST;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_wptr  <= n_wptr;
            r_low   <= n_low;
            r_high  <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw     <= n_raw;
        r_newest  <= n_newest;
        r_rptr    <= n_rptr;
        r_d2      <= n_d2;
        r_sq      <= n_sq;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_cnt     <= n_cnt;
        r_s1      <= n_s1;
        r_s2      <= n_s2;
        r_gsum    <= n_gsum;
        r_gi      <= n_gi;
        r_gj      <= n_gj;
        r_a       <= n_a;
        r_b       <= n_b;
        r_rem     <= n_rem;
        r_root    <= n_root;
        r_bit     <= n_bit;
        r_level   <= n_level;
        r_ocnt    <= n_ocnt;
        r_lastidx <= n_lastidx;
        r_value   <= n_value;
        r_dev     <= n_dev;
        r_idx     <= n_idx;
        r_last    <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LUX) begin
            mem[r_wptr] <= w_lux;
        end
        r_rdata <= mem[r_rptr];
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = (r_state == S_EMIT);
    assign o_activity_level  = r_level;
    assign o_aggregate_value = r_value;
    assign o_deviation       = r_dev;
    assign o_item_index      = r_idx;
    assign o_last_item       = r_last;
    assign o_cfg_ready       = 1'b1;

endmodule

`default_nettype wire

### tb/sv/tb_adaptive_window_aggregator_core.sv
`default_nettype none

module tb_adaptive_window_aggregator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import awa_pkg::*;

    localparam int GRP_SIZE    = 4;
    localparam int GRP_CNT     = 3;
    localparam int WIN         = GRP_SIZE * GRP_CNT;
    localparam int SETTLE      = 200;
    localparam int LONG_HOLD   = 600;
    localparam int HOLD_AFTER  = 200;
    localparam int CYCLE_LIMIT = 1200000;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        t_level             level;
        logic [LUX_W-1:0]   value;
        logic [LUX_W-1:0]   dev;
        logic [OIDX_W-1:0]  idx;
        logic               last;
    } lux_result_t;

    typedef enum int {SEG_STEADY, SEG_SPREAD, SEG_SWING, SEG_NOISE} seg_mode_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RARE} stall_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [RAW_W-1:0]      in_sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [LVL_W-1:0]      out_level;
    logic [LUX_W-1:0]      out_value;
    logic [LUX_W-1:0]      out_dev;
    logic [OIDX_W-1:0]     out_idx;
    logic                  out_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [THR_W-1:0]      cfg_data = '0;

    logic [LUX_W-1:0]      lux_win [WIN];
    int                    win_fill = 0;
    logic [THR_W-1:0]      thr_low = LOW_THR_RST;
    logic [THR_W-1:0]      thr_high = HIGH_THR_RST;

    logic [RAW_W-1:0]      sample_q [$];
    lux_result_t           due_results [$];
    int                    queued_total = 0;
    int                    items_taken = 0;
    int                    error_count = 0;
    int                    cycle_cnt = 0;

    int                    burst_left = 0;
    int                    gap_left = 0;
    int                    hold_left = 0;
    bit                    hold_done = 1'b0;
    stall_mode_t           stall_mode = STALL_NONE;
    int                    mode_left = 0;

    adaptive_window_aggregator_core uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_sample_count    (in_sample),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_activity_level  (out_level),
        .o_aggregate_value (out_value),
        .o_deviation       (out_dev),
        .o_item_index      (out_idx),
        .o_last_item       (out_last),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root[31:0];
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("ERROR @%0d: %s", cycle_cnt, msg);
        end
        error_count++;
    endtask

    task automatic compute_run(input logic [RAW_W-1:0] raw);
        logic [31:0]       prod;
        logic [63:0]       s1;
        logic [63:0]       s2;
        logic [63:0]       spread;
        logic [63:0]       gsum;
        logic [LUX_W-1:0]  dev;
        lux_result_t       r;
        int                i;
        int                g;
        prod = 32'(raw) * 32'(LUX_MUL);
        for (i = WIN - 1; i > 0; i--) begin
            lux_win[i] = lux_win[i-1];
        end
        lux_win[0] = LUX_W'(prod >> LUX_SHIFT);
        if (win_fill < WIN) begin
            win_fill++;
        end
        if (win_fill < WIN) begin
            return;
        end
        s1 = '0;
        s2 = '0;
        for (i = 0; i < WIN; i++) begin
            s1 += 64'(lux_win[i]);
            s2 += 64'(lux_win[i]) * 64'(lux_win[i]);
        end
        spread = (64'(WIN) * s2 > s1 * s1) ? 64'(WIN) * s2 - s1 * s1 : 64'd0;
        dev = LUX_W'(floor_root(spread / 64'(WIN * WIN)));
        r.dev = dev;
        if (dev <= thr_low) begin
            r.level = LVL_LOW;
            r.value = LUX_W'(s1 / 64'(WIN));
            r.idx   = '0;
            r.last  = 1'b1;
            due_results.push_back(r);
        end else if (dev > thr_high) begin
            for (i = 0; i < WIN; i++) begin
                r.level = LVL_HIGH;
                r.value = lux_win[i];
                r.idx   = OIDX_W'(i);
                r.last  = (i == WIN - 1);
                due_results.push_back(r);
            end
        end else begin
            for (g = 0; g < GRP_CNT; g++) begin
                gsum = '0;
                for (i = 0; i < GRP_SIZE; i++) begin
                    gsum += 64'(lux_win[g*GRP_SIZE + i]);
                end
                r.level = LVL_MED;
                r.value = LUX_W'(gsum / 64'(GRP_SIZE));
                r.idx   = OIDX_W'(g);
                r.last  = (g == GRP_CNT - 1);
                due_results.push_back(r);
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                compute_run(in_sample);
                items_taken <= items_taken + 1;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (sample_q.size() > 0) begin
                    in_valid  <= 1'b1;
                    in_sample <= sample_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0: gap_left <= 0;
                            1: gap_left <= $urandom_range(1, 8);
                            default: gap_left <= $urandom_range(1, 150);
                        endcase
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_taken >= HOLD_AFTER) begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(10, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
                default:     out_stall <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        lux_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (due_results.size() == 0) begin
                flag_error($sformatf("unexpected result value %0d", out_value));
            end else begin
                e = due_results.pop_front();
                if (out_level !== e.level)
                    flag_error($sformatf("level %0d, want %0d", out_level, e.level));
                if (out_value !== e.value)
                    flag_error($sformatf("value %0d, want %0d", out_value, e.value));
                if (out_dev !== e.dev)
                    flag_error($sformatf("deviation %0d, want %0d", out_dev, e.dev));
                if (out_idx !== e.idx)
                    flag_error($sformatf("index %0d, want %0d", out_idx, e.idx));
                if (out_last !== e.last)
                    flag_error($sformatf("last %0b, want %0b", out_last, e.last));
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_adaptive_window_aggregator_core NOT OK");
            $finish;
        end
    end

    task automatic wait_idle();
        while (!(items_taken == queued_total && due_results.size() == 0)) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LOW) begin
            thr_low = val;
        end else begin
            thr_high = val;
        end
    endtask

    task automatic queue_sample(input int v);
        sample_q.push_back(RAW_W'(v));
        queued_total++;
    endtask

    task automatic queue_activity(input int count);
        int        left;
        int        seg;
        int        base;
        int        spread;
        int        v;
        seg_mode_t mode;
        left = count;
        while (left > 0) begin
            seg    = $urandom_range(6, 24);
            seg    = (seg > left) ? left : seg;
            mode   = seg_mode_t'($urandom_range(0, 3));
            base   = $urandom_range(0, 4095);
            spread = $urandom_range(1500, 3000);
            repeat (seg) begin
                case (mode)
                    SEG_STEADY: v = base + int'($urandom_range(0, 3));
                    SEG_SPREAD: v = base - spread / 2 + int'($urandom_range(0, spread));
                    SEG_SWING:  v = $urandom_range(0, 1) ? int'($urandom_range(3800, 4095))
                                                         : int'($urandom_range(0, 300));
                    default:    v = $urandom_range(0, 4095);
                endcase
                v = (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
                queue_sample(v);
            end
            left -= seg;
        end
    endtask

    task automatic run_phase(input logic [THR_W-1:0] low, input logic [THR_W-1:0] high,
                             input int count);
        wait_idle();
        write_reg(CFG_LOW, low);
        write_reg(CFG_HIGH, high);
        queue_activity(count);
    endtask

    initial begin
        int k;
        int t;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 12; k++) begin
            queue_sample((k % 2 == 0) ? 0 : 4095);
        end
        queue_sample(1);
        queue_sample(2);
        for (k = 0; k < 10; k++) begin
            queue_sample(2048);
        end

        run_phase(17'd0, 17'd0, 45);
        run_phase(17'd131071, 17'd131071, 45);
        run_phase(17'd0, 17'd131071, 45);
        run_phase(17'd131071, 17'd0, 45);
        run_phase(17'd8000, 17'd24000, 45);
        run_phase(THR_W'($urandom_range(2000, 12000)), THR_W'($urandom_range(14000, 30000)), 45);
        t = $urandom_range(5000, 30000);
        run_phase(THR_W'(t), THR_W'(t), 45);
        run_phase(17'd4000, 17'd16000, 45);

        wait_idle();
        if (error_count == 0) begin
            $display("tb_adaptive_window_aggregator_core OK");
        end else begin
            $display("tb_adaptive_window_aggregator_core NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/awa_pkg.sv
hw/rtl/adaptive_window_aggregator_core.sv
tb/sv/tb_adaptive_window_aggregator_core.sv
